// ===== hdl/bpbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpbr_pkg
// shared widths, constants, codes and controller/datapath interface types
// for the boost gauge with barometric reference
// ----------------------------------------------------------------------------
package bpbr_pkg;

    localparam int MV_W      = 12;
    localparam int HMV_W     = 14;
    localparam int KPA_W     = 15;
    localparam int BOOST_W   = 14;
    localparam int CNT_W     = 8;
    localparam int SUM_W     = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 15;

    // sensor voltage in half millivolts, full scale 5000 mV
    localparam logic [HMV_W-1:0] HALF_MV_MAX = 14'd10000;
    localparam logic [KPA_W-1:0] KPA_LOW     = 15'd110;

    // shared multiplier
    localparam int MUL_A_W = 15;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // floor(s * 31440 / 10000) = (s * PRESS_RECIP) >> PRESS_SHIFT for s <= 10000
    localparam logic [MUL_B_W-1:0] PRESS_RECIP = 27'd52747568;
    localparam int                 PRESS_SHIFT = 24;
    // floor(a * 14504 / 100000) = (a * BOOST_RECIP) >> BOOST_SHIFT for a < 2^15
    localparam logic [MUL_B_W-1:0] BOOST_RECIP = 27'd77867758;
    localparam int                 BOOST_SHIFT = 29;

    // iterative divider
    localparam int                 DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] MOD_STEPS  = 5'd8;
    localparam logic [DIV_CNT_W-1:0] MEAN_STEPS = 5'd23;

    // register reset values
    localparam logic [KPA_W-1:0] REF_START_RESET = 15'd10130;
    localparam logic [KPA_W-1:0] REF_MIN_RESET   = 15'd5000;
    localparam logic [CNT_W-1:0] SAMPLE_RESET    = 8'd10;
    localparam logic [CNT_W-1:0] WINDOW_RESET    = 8'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_EVERY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRAMES = 3'd3;

    typedef enum logic [1:0] {
        MUL_MAN,
        MUL_BAR,
        MUL_BOOST
    } mul_sel_t;

    typedef struct packed {
        logic [MV_W-1:0] manifold_mv;
        logic [MV_W-1:0] baro_mv;
    } in_item_t;

    typedef struct packed {
        logic signed [BOOST_W-1:0] boost_centipsi;
        logic [KPA_W-1:0]          manifold_centikpa;
        logic [KPA_W-1:0]          ref_centikpa;
        logic                      ref_updated;
    } out_item_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     store_man;
        logic     store_bar;
        logic     mod_start;
        logic     update;
        logic     mean_start;
        logic     mean_check;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic need_mean;
        logic out_hold;
    } dp_status_t;

endpackage

// ===== hdl/bpbr_div.sv =====
// ----------------------------------------------------------------------------
// bpbr_div
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module bpbr_div
    import bpbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [CNT_W-1:0]     divisor,
    input  logic [DIV_CNT_W-1:0] steps,
    output logic                 busy,
    output logic [SUM_W-1:0]     quotient,
    output logic [CNT_W-1:0]     remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W:0]       trial;
    logic                 qbit;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[SUM_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[SUM_W-2:0], qbit};
            rem_next = qbit ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/bpbr_dp.sv =====
// ----------------------------------------------------------------------------
// bpbr_dp
// datapath: registers, shared multiplier, window accumulator, output stage
// ----------------------------------------------------------------------------
module bpbr_dp
    import bpbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  in_item_t             in_data,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    // configuration
    logic [KPA_W-1:0] ref_min_reg;
    logic [CNT_W-1:0] sample_every_reg;
    logic [CNT_W-1:0] window_frames_reg;

    // running state
    logic [CNT_W-1:0] frame_count_reg;
    logic [SUM_W-1:0] baro_sum_reg;
    logic [CNT_W-1:0] baro_samples_reg;
    logic [KPA_W-1:0] reference_reg;
    logic             updated_reg;
    logic             out_valid_reg;

    // payload
    logic [MV_W-1:0]   man_mv_reg;
    logic [MV_W-1:0]   bar_mv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KPA_W-1:0]  man_kpa_reg;
    logic [KPA_W-1:0]  bar_kpa_reg;
    out_item_t         out_data_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [KPA_W-1:0]   press;
    logic [KPA_W:0]     diff;
    logic               diff_neg;
    logic [KPA_W:0]     diff_abs;
    logic [BOOST_W-1:0] boost_mag;
    logic [BOOST_W-1:0] boost_val;

    logic                 sample_hit;
    logic [CNT_W-1:0]     samples_new;
    logic [SUM_W-1:0]     sum_new;
    logic [CNT_W-1:0]     fc_new;
    logic                 win_close;
    logic [CNT_W-1:0]     every_eff;

    logic                 div_start;
    logic [SUM_W-1:0]     div_dividend;
    logic [CNT_W-1:0]     div_divisor;
    logic [DIV_CNT_W-1:0] div_steps;
    logic                 div_busy;
    logic [SUM_W-1:0]     div_quo;
    logic [CNT_W-1:0]     div_rem;

    // pin mV x 3 in half millivolts, clamped to 5000 mV
    function automatic logic [HMV_W-1:0] half_mv(input logic [MV_W-1:0] mv);
        logic [HMV_W-1:0] s;
        s = {2'b00, mv} + {1'b0, mv, 1'b0};
        if (s > HALF_MV_MAX)
        begin
            s = HALF_MV_MAX;
        end
        return s;
    endfunction

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MAN:
            begin
                mul_a = {1'b0, half_mv(man_mv_reg)};
                mul_b = PRESS_RECIP;
            end
            MUL_BAR:
            begin
                mul_a = {1'b0, half_mv(bar_mv_reg)};
                mul_b = PRESS_RECIP;
            end
            MUL_BOOST:
            begin
                mul_a = diff_abs[MUL_A_W-1:0];
                mul_b = BOOST_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign press     = KPA_LOW + prod_reg[PRESS_SHIFT +: KPA_W];
    assign diff      = {1'b0, man_kpa_reg} - {1'b0, reference_reg};
    assign diff_neg  = diff[KPA_W];
    assign diff_abs  = diff_neg ? (~diff + 1'b1) : diff;
    assign boost_mag = {1'b0, prod_reg[BOOST_SHIFT +: BOOST_W-1]};
    assign boost_val = diff_neg ? (~boost_mag + 1'b1) : boost_mag;

    // window bookkeeping, seen before this frame's update
    assign sample_hit  = (div_rem == '0);
    assign samples_new = baro_samples_reg + CNT_W'(sample_hit);
    assign sum_new     = baro_sum_reg + (sample_hit ? SUM_W'(bar_kpa_reg) : '0);
    assign fc_new      = frame_count_reg + 1'b1;
    assign win_close   = (fc_new >= window_frames_reg);
    assign every_eff   = (sample_every_reg == '0) ? CNT_W'(1) : sample_every_reg;

    assign div_start    = cmd.mod_start | cmd.mean_start;
    assign div_dividend = cmd.mean_start ? sum_new : {frame_count_reg, {(SUM_W-CNT_W){1'b0}}};
    assign div_divisor  = cmd.mean_start ? samples_new : every_eff;
    assign div_steps    = cmd.mean_start ? MEAN_STEPS : MOD_STEPS;

    bpbr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_min_reg       <= REF_MIN_RESET;
            sample_every_reg  <= SAMPLE_RESET;
            window_frames_reg <= WINDOW_RESET;
            frame_count_reg   <= '0;
            baro_sum_reg      <= '0;
            baro_samples_reg  <= '0;
            reference_reg     <= REF_START_RESET;
            updated_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    // the starting reference takes effect at once
                    CFG_REF_START:     reference_reg     <= cfg_data;
                    CFG_REF_MIN:       ref_min_reg       <= cfg_data;
                    CFG_SAMPLE_EVERY:  sample_every_reg  <= cfg_data[CNT_W-1:0];
                    CFG_WINDOW_FRAMES: window_frames_reg <= cfg_data[CNT_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.load_in)
            begin
                updated_reg <= 1'b0;
            end
            if (cmd.update)
            begin
                if (win_close)
                begin
                    frame_count_reg  <= '0;
                    baro_sum_reg     <= '0;
                    baro_samples_reg <= '0;
                end
                else
                begin
                    frame_count_reg  <= fc_new;
                    baro_sum_reg     <= sum_new;
                    baro_samples_reg <= samples_new;
                end
            end
            if (cmd.mean_check && (div_quo >= SUM_W'(ref_min_reg)))
            begin
                reference_reg <= div_quo[KPA_W-1:0];
                updated_reg   <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            man_mv_reg <= in_data.manifold_mv;
            bar_mv_reg <= in_data.baro_mv;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.store_man)
        begin
            man_kpa_reg <= press;
        end
        if (cmd.store_bar)
        begin
            bar_kpa_reg <= press;
        end
        if (cmd.out_load)
        begin
            out_data_reg.boost_centipsi    <= boost_val;
            out_data_reg.manifold_centikpa <= man_kpa_reg;
            out_data_reg.ref_centikpa      <= reference_reg;
            out_data_reg.ref_updated       <= updated_reg;
        end
    end

    assign status.div_busy  = div_busy;
    assign status.need_mean = win_close && (samples_new != '0);
    assign status.out_hold  = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/bpbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpbr_ctrl
// frame sequencer: steps the datapath through one transaction at a time
// ----------------------------------------------------------------------------
module bpbr_ctrl
    import bpbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_MAN,
        S_MUL_BAR,
        S_WAIT_MOD,
        S_WAIT_MEAN,
        S_BOOST,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_MAN;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL_MAN;
                end
            end
            S_MUL_MAN:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_MAN;
                state_next  = S_MUL_BAR;
            end
            S_MUL_BAR:
            begin
                cmd.store_man = 1'b1;
                cmd.mul_go    = 1'b1;
                cmd.mul_sel   = MUL_BAR;
                cmd.mod_start = 1'b1;
                state_next    = S_WAIT_MOD;
            end
            S_WAIT_MOD:
            begin
                cmd.store_bar = 1'b1;
                if (!status.div_busy)
                begin
                    cmd.update     = 1'b1;
                    cmd.mean_start = status.need_mean;
                    state_next     = status.need_mean ? S_WAIT_MEAN : S_BOOST;
                end
            end
            S_WAIT_MEAN:
            begin
                if (!status.div_busy)
                begin
                    cmd.mean_check = 1'b1;
                    state_next     = S_BOOST;
                end
            end
            S_BOOST:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_BOOST;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!status.out_hold)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== hdl/boost_pressure_with_baro_reference.sv =====
// ----------------------------------------------------------------------------
// boost_pressure_with_baro_reference
// boost gauge core: manifold and barometric pressure, windowed reference
// ----------------------------------------------------------------------------
// Each input transaction is one update frame with two pin readings in mV. The
// block returns exactly one result transaction per frame: absolute manifold
// pressure, the reference in use and boost in 0.01 psi. The shared bit-serial
// divider runs 8 steps for the sampling phase check on every frame, and 23
// steps for the window mean on a frame that closes a window holding samples.
// The next frame can be accepted in the cycle after the result is loaded; a
// result still stalled downstream when the next one is ready holds the
// sequencer until it is taken. One frame is in flight at a time; the result
// register lets the next frame be accepted while a result still waits
// downstream. The user must write registers over the plain write port only
// while no frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module boost_pressure_with_baro_reference
    import bpbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // frame input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    // result output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: owns the frame flow and the input handshake
    bpbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: conversion, window averaging, boost and output register
    bpbr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // an accepted frame keeps the input side closed until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after frame accept");

    // a stalled result stays on the port unchanged
    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // manifold pressure always lies on the sensor scale
    a_manifold_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.manifold_centikpa >= KPA_LOW &&
                       out_data.manifold_centikpa <= 15'd31550))
        else $error("manifold pressure off scale");
`endif

endmodule

// ===== tb/sv/boost_pressure_with_baro_reference_tb.sv =====
// ----------------------------------------------------------------------------
// boost_pressure_with_baro_reference_tb
// self-checking testbench for the boost gauge core with windowed reference
// ----------------------------------------------------------------------------
// A table of directed frames and register writes comes first. Its rows cover
// the input extremes, the clamp edge, the zero sample interval and the zero
// window length. They also cover a window shortened below the running frame
// count, a rejected mean, a mean equal to the minimum, and register values
// outside their nominal range. Random phases follow, each with its own
// register settings. The barometric pin mostly wanders around a per-phase
// level, so window means land on both sides of the minimum. A local model of
// the gauge predicts every result transaction. The output monitor compares
// each field against the oldest prediction. Both channels see random gaps.
// ----------------------------------------------------------------------------
module boost_pressure_with_baro_reference_tb;

    import bpbr_pkg::*;

    localparam int KPA_SPAN   = 31440;
    localparam int N_DIRECTED = 43;
    localparam int N_FRAMES   = 1550;

    // clock, reset and block inputs, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;

    // local copy of the gauge registers and window state
    logic [KPA_W-1:0] g_ref_start     = REF_START_RESET;
    logic [KPA_W-1:0] g_ref_min       = REF_MIN_RESET;
    logic [CNT_W-1:0] g_sample_every  = SAMPLE_RESET;
    logic [CNT_W-1:0] g_window_frames = WINDOW_RESET;
    logic [CNT_W-1:0] g_frame_count   = '0;
    logic [SUM_W-1:0] g_baro_sum      = '0;
    logic [CNT_W-1:0] g_baro_samples  = '0;
    logic [KPA_W-1:0] g_reference     = REF_START_RESET;

    // readings predicted for accepted frames, oldest first
    out_item_t pending_readings[$];
    int        mismatch_count = 0;
    out_item_t want;
    logic      field_bad;

    // directed table: register writes, predicted frames, frames with a typed result
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_FRAME,
        ROW_CHECK
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     value;
        logic [MV_W-1:0]      man_mv;
        logic [MV_W-1:0]      bar_mv;
        out_item_t            typed;
    } dir_row_t;

    dir_row_t directed [N_DIRECTED] = '{
        // reset settings: both pins at zero, then both at full scale
        '{ROW_CHECK, CFG_REF_START, 15'd0, 12'd0, 12'd0,
          '{-14'sd1453, 15'd110, 15'd10130, 1'b0}},
        '{ROW_CHECK, CFG_REF_START, 15'd0, 12'd4095, 12'd4095,
          '{14'sd3106, 15'd31550, 15'd10130, 1'b0}},
        // clamp edge and alternating bit patterns
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd3333, 12'd3334, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd1, 12'd4094, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd2730, 12'd2048, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd1365, 12'd2047, '0},
        // window shortened below the running count, low mean rejected
        '{ROW_WRITE, CFG_WINDOW_FRAMES, 15'd3, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd2000, 12'd2000, '0},
        // zero sample interval samples every frame
        '{ROW_WRITE, CFG_REF_MIN, 15'd0, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_SAMPLE_EVERY, 15'd0, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd3000, 12'd2000, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd100, 12'd2100, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd4000, 12'd1900, '0},
        // zero window closes on every frame
        '{ROW_WRITE, CFG_WINDOW_FRAMES, 15'd0, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd2500, 12'd4095, '0},
        '{ROW_CHECK, CFG_REF_START, 15'd0, 12'd0, 12'd0,
          '{14'sd0, 15'd110, 15'd110, 1'b1}},
        // starting reference and minimum above the pressure range
        '{ROW_WRITE, CFG_REF_START, 15'd32767, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_REF_MIN, 15'd32767, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd0, 12'd4095, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd4095, 12'd0, '0},
        '{ROW_WRITE, CFG_REF_START, 15'd0, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd4095, 12'd4095, '0},
        // longest window and interval, then shortened: mean equal to minimum
        '{ROW_WRITE, CFG_REF_MIN, 15'd31550, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_WINDOW_FRAMES, 15'd255, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_SAMPLE_EVERY, 15'd255, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_REF_START, 15'd110, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd4095, 12'd4095, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd2048, 12'd1024, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd512, 12'd256, '0},
        '{ROW_WRITE, CFG_WINDOW_FRAMES, 15'd2, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd1000, 12'd1000, '0},
        // single frame windows from the top of the range
        '{ROW_WRITE, CFG_REF_START, 15'd31550, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_SAMPLE_EVERY, 15'd1, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_WINDOW_FRAMES, 15'd1, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_REF_MIN, 15'd5000, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd3500, 12'd1500, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd700, 12'd3900, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd2222, 12'd2222, '0},
        // back to the reset settings
        '{ROW_WRITE, CFG_REF_START, 15'd10130, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_SAMPLE_EVERY, 15'd10, 12'd0, 12'd0, '0},
        '{ROW_WRITE, CFG_WINDOW_FRAMES, 15'd100, 12'd0, 12'd0, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd1800, 12'd2050, '0},
        '{ROW_FRAME, CFG_REF_START, 15'd0, 12'd3100, 12'd2050, '0}
    };

    boost_pressure_with_baro_reference i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // pin millivolts to absolute pressure: x3 in half mV, clamp, linear map
    function automatic logic [KPA_W-1:0] mv_to_centikpa(input logic [MV_W-1:0] mv);
        int unsigned half_mv;
        half_mv = int'(mv) * 3;
        if (half_mv > int'(HALF_MV_MAX))
            half_mv = int'(HALF_MV_MAX);
        return KPA_W'(int'(KPA_LOW) + (half_mv * KPA_SPAN) / int'(HALF_MV_MAX));
    endfunction

    // one frame through the gauge: sampling, window close, boost
    function automatic out_item_t gauge_reading(input in_item_t f);
        logic [KPA_W-1:0] man;
        logic [KPA_W-1:0] bar;
        int unsigned      every_n;
        int unsigned      mean;
        logic             upd;
        longint           diff;
        longint           boost;
        out_item_t        r;
        man     = mv_to_centikpa(f.manifold_mv);
        bar     = mv_to_centikpa(f.baro_mv);
        every_n = (g_sample_every == 0) ? 1 : int'(g_sample_every);
        upd     = 1'b0;
        if ((int'(g_frame_count) % every_n) == 0)
        begin
            g_baro_sum     = g_baro_sum + SUM_W'(bar);
            g_baro_samples = g_baro_samples + 1'b1;
        end
        g_frame_count = g_frame_count + 1'b1;
        if (g_frame_count >= g_window_frames)
        begin
            g_frame_count = '0;
            // an empty window keeps the reference
            if (g_baro_samples != 0)
            begin
                mean = int'(g_baro_sum) / int'(g_baro_samples);
                if (mean >= int'(g_ref_min))
                begin
                    g_reference = KPA_W'(mean);
                    upd         = 1'b1;
                end
            end
            g_baro_sum     = '0;
            g_baro_samples = '0;
        end
        diff = longint'(man) - longint'(g_reference);
        // truncation toward zero on both signs
        if (diff >= 0)
            boost = (diff * 14504) / 100000;
        else
            boost = -(((-diff) * 14504) / 100000);
        r.boost_centipsi    = boost[BOOST_W-1:0];
        r.manifold_centikpa = man;
        r.ref_centikpa      = g_reference;
        r.ref_updated       = upd;
        return r;
    endfunction

    // gap before a frame: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // drop valid and hold until every predicted reading is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // register write while idle, mirrored into the local model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_REF_START:
            begin
                // writing the starting reference also reloads the reference
                g_ref_start = value[KPA_W-1:0];
                g_reference = value[KPA_W-1:0];
            end
            CFG_REF_MIN:       g_ref_min       = value[KPA_W-1:0];
            CFG_SAMPLE_EVERY:  g_sample_every  = value[CNT_W-1:0];
            CFG_WINDOW_FRAMES: g_window_frames = value[CNT_W-1:0];
            default:           ;
        endcase
    endtask

    // drive one frame and wait for its transaction; valid stays high on return
    task automatic send_frame(input in_item_t f, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stimulus: reset, directed table, random phases, drain
    initial
    begin
        int          sent;
        int          phase_len;
        int          k;
        int          bar_level;
        int          b;
        bit          calm;
        in_item_t    f;
        out_item_t   guess;
        logic [CFG_W-1:0] v;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sent = 0;
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WRITE)
                write_reg(directed[i].idx, directed[i].value);
            else
            begin
                f.manifold_mv = directed[i].man_mv;
                f.baro_mv     = directed[i].bar_mv;
                send_frame(f, pick_gap(1'b0));
                guess = gauge_reading(f);
                // typed rows keep the model state moving but check the table value
                if (directed[i].kind == ROW_CHECK)
                    pending_readings.push_back(directed[i].typed);
                else
                    pending_readings.push_back(guess);
                sent++;
            end
        end

        while (sent < N_FRAMES)
        begin
            // fresh settings per phase, extremes and odd values now and then
            case ($urandom_range(0, 9))
                0:       v = 15'd110;
                1:       v = 15'd31550;
                2:       v = CFG_W'($urandom);
                default: v = CFG_W'($urandom_range(8000, 12000));
            endcase
            write_reg(CFG_REF_START, v);
            case ($urandom_range(0, 9))
                0:       v = 15'd0;
                1:       v = 15'd31550;
                2:       v = CFG_W'($urandom);
                default: v = CFG_W'($urandom_range(3000, 10000));
            endcase
            write_reg(CFG_REF_MIN, v);
            case ($urandom_range(0, 9))
                0:       v = 15'd0;
                1:       v = 15'd255;
                2:       v = CFG_W'($urandom_range(0, 255));
                default: v = CFG_W'($urandom_range(1, 4));
            endcase
            write_reg(CFG_SAMPLE_EVERY, v);
            case ($urandom_range(0, 9))
                0:       v = 15'd0;
                1:       v = 15'd255;
                2:       v = CFG_W'($urandom_range(0, 255));
                default: v = CFG_W'($urandom_range(1, 24));
            endcase
            write_reg(CFG_WINDOW_FRAMES, v);

            phase_len = $urandom_range(60, 160);
            calm      = ($urandom_range(0, 3) == 0);
            bar_level = $urandom_range(0, 4095);
            for (k = 0; k < phase_len && sent < N_FRAMES; k++)
            begin
                // now and then let the block run dry before the next frame
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
                case ($urandom_range(0, 19))
                    0:       f.manifold_mv = 12'd0;
                    1:       f.manifold_mv = 12'd4095;
                    2:       f.manifold_mv = 12'd3333;
                    3:       f.manifold_mv = 12'd3334;
                    default: f.manifold_mv = MV_W'($urandom);
                endcase
                // baro pin mostly near the phase level, the rest anywhere
                if ($urandom_range(0, 3) != 0)
                begin
                    b = bar_level + $urandom_range(0, 40) - 20;
                    if (b < 0)
                        b = 0;
                    if (b > 4095)
                        b = 4095;
                    f.baro_mv = MV_W'(b);
                end
                else
                    f.baro_mv = MV_W'($urandom);
                send_frame(f, pick_gap(calm));
                pending_readings.push_back(gauge_reading(f));
                sent++;
            end
        end

        // drain and let the block settle
        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("[boost_pressure_with_baro_reference] OK");
        else
            $display("[boost_pressure_with_baro_reference] ERROR");
        $finish;
    end

    // receiver back pressure: free runs, short stalls, a few long ones
    initial
    begin
        int free_len;
        int stall_len;
        int r;
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                free_len = $urandom_range(100, 400);
            else
                free_len = $urandom_range(0, 12);
            repeat (free_len)
            begin
                @(posedge clk);
                out_stall <= 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                stall_len = $urandom_range(1, 3);
            else if (r < 95)
                stall_len = $urandom_range(5, 20);
            else
                stall_len = $urandom_range(30, 60);
            repeat (stall_len)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    // result monitor: every output transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: boost %0d manifold %0d ref %0d updated %0d",
                             out_data.boost_centipsi, out_data.manifold_centikpa,
                             out_data.ref_centikpa, out_data.ref_updated);
            end
            else
            begin
                want      = pending_readings.pop_front();
                field_bad = (out_data.boost_centipsi    !== want.boost_centipsi)
                         || (out_data.manifold_centikpa !== want.manifold_centikpa)
                         || (out_data.ref_centikpa      !== want.ref_centikpa)
                         || (out_data.ref_updated       !== want.ref_updated);
                if (field_bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch (expected/actual): boost %0d/%0d manifold %0d/%0d",
                                 want.boost_centipsi, out_data.boost_centipsi,
                                 want.manifold_centikpa, out_data.manifold_centikpa,
                                 " ref %0d/%0d updated %0d/%0d",
                                 want.ref_centikpa, out_data.ref_centikpa,
                                 want.ref_updated, out_data.ref_updated);
                end
            end
        end
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #15000000;
        $display("[boost_pressure_with_baro_reference] ERROR");
        $finish;
    end

endmodule
